FILE: design/heightmap_vertex_normal_top_macros.svh
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_top_macros
// assertion macros shared by the heightmap vertex normal modules
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_VERTEX_NORMAL_TOP_MACROS_SVH
`define HEIGHTMAP_VERTEX_NORMAL_TOP_MACROS_SVH

// consequent checked in the same cycle
`define HVN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define HVN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/hvn_pkg.sv
// ----------------------------------------------------------------------------
// hvn_pkg
// types, constants and the face table of the heightmap vertex normal unit
// ----------------------------------------------------------------------------
package hvn_pkg;

  localparam int MAX_COLS   = 128;
  localparam int MAX_ROWS   = 128;
  localparam int ROW_W      = 7;
  localparam int COL_W      = 7;
  localparam int ADDR_W     = ROW_W + COL_W;
  localparam int DEPTH      = MAX_ROWS * MAX_COLS;
  localparam int HGT_W      = 8;
  localparam int GRID_W     = 8;
  localparam int STEP_W     = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int VEC_W      = 42;
  localparam int MAG_W      = 42;
  localparam int Q_W        = 22;
  localparam int ACC_W      = 26;
  localparam int OUT_W      = 16;
  localparam int FACE_IDX_W = 5;
  localparam int FACE_CNT_W = 3;
  localparam int FACE_NUM_W = 4;
  localparam int FRAC_FACE  = 20;
  localparam int FRAC_FINAL = 15;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 2'd0,
    REG_GRID_HEIGHT = 2'd1,
    REG_STEP_WIDTH  = 2'd2,
    REG_STEP_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    RD_CENTRE = 2'd0,
    RD_N1     = 2'd1,
    RD_N2     = 2'd2
  } rd_sel_t;

  typedef enum logic [3:0] {
    C_IDLE, C_CHECK, C_RDC, C_LDH0, C_RD1, C_RD2, C_RD3,
    C_MUL1, C_MUL2, C_NST, C_NWAIT, C_FST, C_FWAIT, C_OUT
  } ctrl_state_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DINIT, N_DIV, N_DONE
  } norm_state_t;

  // neighbour offsets: a is a column step, b a row step
  localparam logic signed [1:0] OFF_ZERO = 2'sd0;
  localparam logic signed [1:0] OFF_POS  = 2'sd1;
  localparam logic signed [1:0] OFF_NEG  = -2'sd1;

  typedef struct packed {
    logic signed [1:0] a1;
    logic signed [1:0] b1;
    logic signed [1:0] a2;
    logic signed [1:0] b2;
  } face_t;

  localparam face_t FACE_TABLE [20] = '{
    '{OFF_ZERO, OFF_POS,  OFF_POS,  OFF_ZERO},
    '{OFF_ZERO, OFF_NEG,  OFF_NEG,  OFF_ZERO},
    '{OFF_POS,  OFF_ZERO, OFF_ZERO, OFF_NEG},
    '{OFF_NEG,  OFF_ZERO, OFF_ZERO, OFF_POS},
    '{OFF_NEG,  OFF_ZERO, OFF_ZERO, OFF_POS},
    '{OFF_ZERO, OFF_POS,  OFF_POS,  OFF_ZERO},
    '{OFF_POS,  OFF_ZERO, OFF_ZERO, OFF_NEG},
    '{OFF_ZERO, OFF_POS,  OFF_POS,  OFF_ZERO},
    '{OFF_ZERO, OFF_NEG,  OFF_NEG,  OFF_ZERO},
    '{OFF_POS,  OFF_ZERO, OFF_ZERO, OFF_NEG},
    '{OFF_ZERO, OFF_NEG,  OFF_NEG,  OFF_ZERO},
    '{OFF_NEG,  OFF_ZERO, OFF_ZERO, OFF_POS},
    '{OFF_NEG,  OFF_ZERO, OFF_NEG,  OFF_POS},
    '{OFF_NEG,  OFF_POS,  OFF_ZERO, OFF_POS},
    '{OFF_ZERO, OFF_POS,  OFF_POS,  OFF_POS},
    '{OFF_POS,  OFF_POS,  OFF_POS,  OFF_ZERO},
    '{OFF_POS,  OFF_ZERO, OFF_POS,  OFF_NEG},
    '{OFF_POS,  OFF_NEG,  OFF_ZERO, OFF_NEG},
    '{OFF_ZERO, OFF_NEG,  OFF_NEG,  OFF_NEG},
    '{OFF_NEG,  OFF_NEG,  OFF_NEG,  OFF_ZERO}
  };

  // first face of each grid position class
  localparam logic [FACE_IDX_W-1:0] FS_TOP_LEFT  = 5'd0;
  localparam logic [FACE_IDX_W-1:0] FS_BOT_RIGHT = 5'd1;
  localparam logic [FACE_IDX_W-1:0] FS_BOT_LEFT  = 5'd2;
  localparam logic [FACE_IDX_W-1:0] FS_TOP_RIGHT = 5'd3;
  localparam logic [FACE_IDX_W-1:0] FS_TOP       = 5'd4;
  localparam logic [FACE_IDX_W-1:0] FS_LEFT      = 5'd6;
  localparam logic [FACE_IDX_W-1:0] FS_BOTTOM    = 5'd8;
  localparam logic [FACE_IDX_W-1:0] FS_RIGHT     = 5'd10;
  localparam logic [FACE_IDX_W-1:0] FS_INNER     = 5'd12;

  typedef struct packed {
    logic                  take;
    logic                  clr_acc;
    rd_sel_t               rd_sel;
    logic                  ld_h0;
    logic                  ld_h1;
    logic                  ld_h2;
    logic                  mul1;
    logic                  mul2;
    logic                  norm_start;
    logic                  frac_face;
    logic                  sel_final;
    logic                  acc_add;
    logic                  load_out;
    logic [FACE_IDX_W-1:0] face_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic                  coord_err;
    logic [FACE_IDX_W-1:0] face_start;
    logic [FACE_NUM_W-1:0] face_count;
    logic                  norm_done;
    logic                  out_free;
  } dp_status_t;

endpackage

FILE: design/hvn_norm.sv
// ----------------------------------------------------------------------------
// hvn_norm
// iterative vector normaliser: scale, sum of squares, square root, divide
// ----------------------------------------------------------------------------
`include "heightmap_vertex_normal_top_macros.svh"

module hvn_norm (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               frac_face,
  input  logic signed [hvn_pkg::VEC_W-1:0]   vec_in [3],
  output logic                               done,
  output logic signed [hvn_pkg::Q_W-1:0]     q_out [3]
);
  import hvn_pkg::*;

  localparam int SUM_W  = 62;
  localparam int SQ_W   = 63;
  localparam int NUM_W  = 52;
  localparam int ROOT_W = 31;
  localparam int REM_W  = 32;
  localparam int LO_W   = 21;
  localparam int QM_W   = 21;
  localparam int CNT_W  = 5;

  localparam logic [MAG_W-1:0] LIM_R4 = MAG_W'(1) << 34;
  localparam logic [MAG_W-1:0] LIM_R1 = MAG_W'(1) << 30;
  localparam logic [MAG_W-1:0] LIM_L4 = MAG_W'(1) << 25;
  localparam logic [MAG_W-1:0] LIM_L1 = MAG_W'(1) << 29;

  norm_state_t        state_r, state_nxt;
  logic [MAG_W-1:0]   mag_r [3];
  logic [MAG_W-1:0]   mag_nxt [3];
  logic               neg_r [3];
  logic               neg_nxt [3];
  logic               frac_r, frac_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [59:0]        sq_r, sq_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SQ_W-1:0]    n_r, n_nxt;
  logic [SQ_W-1:0]    rt_r, rt_nxt;
  logic [SQ_W-1:0]    bit_r, bit_nxt;
  logic [ROOT_W-1:0]  root_r, root_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [LO_W-1:0]    lo_r, lo_nxt;
  logic [QM_W-1:0]    qm_r, qm_nxt;
  logic [1:0]         kc_r, kc_nxt;
  logic signed [Q_W-1:0] q_r [3];
  logic signed [Q_W-1:0] q_nxt [3];

  logic [MAG_W-1:0]   mx;
  logic [29:0]        mag_sel;
  logic [SQ_W-1:0]    trial;
  logic [NUM_W-1:0]   num;
  logic [REM_W-1:0]   trem;
  logic               qbit;

  always_comb begin
    mx = mag_r[0];
    if (mag_r[1] > mx) begin
      mx = mag_r[1];
    end
    if (mag_r[2] > mx) begin
      mx = mag_r[2];
    end
  end

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    frac_nxt  = frac_r;
    cnt_nxt   = cnt_r;
    sq_nxt    = sq_r;
    sum_nxt   = sum_r;
    n_nxt     = n_r;
    rt_nxt    = rt_r;
    bit_nxt   = bit_r;
    root_nxt  = root_r;
    rem_nxt   = rem_r;
    lo_nxt    = lo_r;
    qm_nxt    = qm_r;
    kc_nxt    = kc_r;
    q_nxt     = q_r;
    done      = 1'b0;
    mag_sel   = '0;
    trial     = rt_r + bit_r;
    num       = '0;
    trem      = {rem_r[REM_W-2:0], lo_r[LO_W-1]};
    qbit      = 1'b0;
    case (state_r)
      N_IDLE: begin
        if (start) begin
          for (int k = 0; k < 3; k++) begin
            neg_nxt[k] = vec_in[k][VEC_W-1];
            mag_nxt[k] = vec_in[k][VEC_W-1] ? MAG_W'(-vec_in[k]) : MAG_W'(vec_in[k]);
          end
          frac_nxt  = frac_face;
          state_nxt = N_SHIFT;
        end
      end
      N_SHIFT: begin
        if (mx == '0) begin
          for (int k = 0; k < 3; k++) begin
            q_nxt[k] = '0;
          end
          state_nxt = N_DONE;
        end else if (mx >= LIM_R4) begin
          for (int k = 0; k < 3; k++) begin
            mag_nxt[k] = mag_r[k] >> 4;
          end
        end else if (mx >= LIM_R1) begin
          for (int k = 0; k < 3; k++) begin
            mag_nxt[k] = mag_r[k] >> 1;
          end
        end else if (mx < LIM_L4) begin
          for (int k = 0; k < 3; k++) begin
            mag_nxt[k] = mag_r[k] << 4;
          end
        end else if (mx < LIM_L1) begin
          for (int k = 0; k < 3; k++) begin
            mag_nxt[k] = mag_r[k] << 1;
          end
        end else begin
          sq_nxt    = '0;
          sum_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = N_SQ;
        end
      end
      N_SQ: begin
        case (cnt_r[1:0])
          2'd0:    mag_sel = mag_r[0][29:0];
          2'd1:    mag_sel = mag_r[1][29:0];
          2'd2:    mag_sel = mag_r[2][29:0];
          default: mag_sel = '0;
        endcase
        sum_nxt = sum_r + SUM_W'(sq_r);
        sq_nxt  = mag_sel * mag_sel;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r[1:0] == 2'd3) begin
          n_nxt     = SQ_W'(sum_r + SUM_W'(sq_r));
          rt_nxt    = '0;
          bit_nxt   = SQ_W'(1) << 62;
          state_nxt = N_SQRT;
        end
      end
      N_SQRT: begin
        if (n_r >= trial) begin
          n_nxt  = n_r - trial;
          rt_nxt = (rt_r >> 1) + bit_r;
        end else begin
          rt_nxt = rt_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == SQ_W'(1)) begin
          root_nxt  = rt_nxt[ROOT_W-1:0];
          kc_nxt    = '0;
          state_nxt = N_DINIT;
        end
      end
      N_DINIT: begin
        case (kc_r)
          2'd0:    mag_sel = mag_r[0][29:0];
          2'd1:    mag_sel = mag_r[1][29:0];
          2'd2:    mag_sel = mag_r[2][29:0];
          default: mag_sel = '0;
        endcase
        // rounding term is half the root
        if (frac_r) begin
          num     = {2'b00, mag_sel, 20'b0} + {22'b0, root_r[ROOT_W-1:1]};
          rem_nxt = {1'b0, num[NUM_W-1:21]};
          lo_nxt  = num[20:0];
          cnt_nxt = CNT_W'(FRAC_FACE);
        end else begin
          num     = {7'b0, mag_sel, 15'b0} + {22'b0, root_r[ROOT_W-1:1]};
          rem_nxt = num[47:16];
          lo_nxt  = {num[15:0], 5'b0};
          cnt_nxt = CNT_W'(FRAC_FINAL);
        end
        qm_nxt    = '0;
        state_nxt = N_DIV;
      end
      N_DIV: begin
        if (trem >= {1'b0, root_r}) begin
          rem_nxt = trem - {1'b0, root_r};
          qbit    = 1'b1;
        end else begin
          rem_nxt = trem;
        end
        qm_nxt  = {qm_r[QM_W-2:0], qbit};
        lo_nxt  = {lo_r[LO_W-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          q_nxt[kc_r] = neg_r[kc_r] ? -$signed({1'b0, qm_nxt}) : $signed({1'b0, qm_nxt});
          if (kc_r == 2'd2) begin
            state_nxt = N_DONE;
          end else begin
            kc_nxt    = kc_r + 2'd1;
            state_nxt = N_DINIT;
          end
        end
      end
      N_DONE: begin
        done      = 1'b1;
        state_nxt = N_IDLE;
      end
      default: state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    frac_r <= frac_nxt;
    cnt_r  <= cnt_nxt;
    sq_r   <= sq_nxt;
    sum_r  <= sum_nxt;
    n_r    <= n_nxt;
    rt_r   <= rt_nxt;
    bit_r  <= bit_nxt;
    root_r <= root_nxt;
    rem_r  <= rem_nxt;
    lo_r   <= lo_nxt;
    qm_r   <= qm_nxt;
    kc_r   <= kc_nxt;
    q_r    <= q_nxt;
  end

  assign q_out = q_r;

  `HVN_ASSERT_SAME(a_sqrt_bit_onehot, state_r == N_SQRT, $onehot(bit_r), "root bit not one-hot")
  `HVN_ASSERT_SAME(a_div_rem_below_root, state_r == N_DIV, rem_r < {1'b0, root_r}, "remainder not below root")
  `HVN_ASSERT_SAME(a_sq_scaled, state_r == N_SQ, (mx < LIM_R1) && (mx >= LIM_L1), "largest component not scaled")

endmodule

FILE: design/hvn_dp.sv
// ----------------------------------------------------------------------------
// hvn_dp
// datapath: configuration, height memory, face vectors, accumulator, output
// ----------------------------------------------------------------------------
module hvn_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hvn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hvn_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_accept,
  input  logic                              in_command,
  input  logic [hvn_pkg::ROW_W-1:0]         in_row,
  input  logic [hvn_pkg::COL_W-1:0]         in_col,
  input  logic [hvn_pkg::HGT_W-1:0]         in_height,
  input  hvn_pkg::ctrl_cmd_t                cmd,
  output hvn_pkg::dp_status_t               st,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hvn_pkg::OUT_W-1:0]  out_normal_x,
  output logic signed [hvn_pkg::OUT_W-1:0]  out_normal_y,
  output logic signed [hvn_pkg::OUT_W-1:0]  out_normal_z,
  output logic                              out_coord_error
);
  import hvn_pkg::*;

  function automatic logic signed [9:0] off_mul(input logic signed [8:0] d,
                                                input logic signed [1:0] o);
    case (o)
      OFF_POS: return {d[8], d};
      OFF_NEG: return -{d[8], d};
      default: return 10'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] off_prod(input logic signed [1:0] x,
                                                 input logic signed [1:0] y);
    logic signed [3:0] p;
    p = x * y;
    return p[1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_q(input logic signed [Q_W-1:0] q);
    if (q > Q_W'(32767)) begin
      return 16'sh7fff;
    end else if (q < -Q_W'(32768)) begin
      return 16'sh8000;
    end
    return q[OUT_W-1:0];
  endfunction

  // configuration
  logic [GRID_W-1:0] grid_w_r, grid_h_r;
  logic [STEP_W-1:0] step_w_r, step_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= GRID_W'(MAX_COLS);
      grid_h_r <= GRID_W'(MAX_ROWS);
      step_w_r <= STEP_W'(256);
      step_h_r <= STEP_W'(256);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH:  grid_w_r <= cfg_wdata[GRID_W-1:0];
        REG_GRID_HEIGHT: grid_h_r <= cfg_wdata[GRID_W-1:0];
        REG_STEP_WIDTH:  step_w_r <= cfg_wdata;
        REG_STEP_HEIGHT: step_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // grid position class
  logic [ROW_W-1:0]      row_r;
  logic [COL_W-1:0]      col_r;
  logic [GRID_W-1:0]     gw_c, gh_c, lw, lh;
  logic                  r0, c0, rl, cl;
  logic                  coord_err;
  logic [FACE_IDX_W-1:0] face_start;
  logic [FACE_NUM_W-1:0] face_count;
  logic                  norm_done;
  logic                  out_free;

  assign st = {coord_err, face_start, face_count, norm_done, out_free};

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      row_r <= in_row;
      col_r <= in_col;
    end
  end

  always_comb begin
    if (grid_w_r < GRID_W'(2)) begin
      gw_c = GRID_W'(2);
    end else if (grid_w_r > GRID_W'(MAX_COLS)) begin
      gw_c = GRID_W'(MAX_COLS);
    end else begin
      gw_c = grid_w_r;
    end
    if (grid_h_r < GRID_W'(2)) begin
      gh_c = GRID_W'(2);
    end else if (grid_h_r > GRID_W'(MAX_ROWS)) begin
      gh_c = GRID_W'(MAX_ROWS);
    end else begin
      gh_c = grid_h_r;
    end
    lw = gw_c - GRID_W'(1);
    lh = gh_c - GRID_W'(1);
    r0 = (row_r == '0);
    c0 = (col_r == '0);
    rl = ({1'b0, row_r} == lh);
    cl = ({1'b0, col_r} == lw);
    coord_err = ({1'b0, row_r} >= gh_c) || ({1'b0, col_r} >= gw_c);
    if (r0 && c0) begin
      face_start = FS_TOP_LEFT;
      face_count = FACE_NUM_W'(1);
    end else if (rl && cl) begin
      face_start = FS_BOT_RIGHT;
      face_count = FACE_NUM_W'(1);
    end else if (rl && c0) begin
      face_start = FS_BOT_LEFT;
      face_count = FACE_NUM_W'(1);
    end else if (r0 && cl) begin
      face_start = FS_TOP_RIGHT;
      face_count = FACE_NUM_W'(1);
    end else if (r0) begin
      face_start = FS_TOP;
      face_count = FACE_NUM_W'(2);
    end else if (c0) begin
      face_start = FS_LEFT;
      face_count = FACE_NUM_W'(2);
    end else if (rl) begin
      face_start = FS_BOTTOM;
      face_count = FACE_NUM_W'(2);
    end else if (cl) begin
      face_start = FS_RIGHT;
      face_count = FACE_NUM_W'(2);
    end else begin
      face_start = FS_INNER;
      face_count = FACE_NUM_W'(8);
    end
  end

  // height memory
  logic [HGT_W-1:0]  mem [DEPTH];
  logic [HGT_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0] raddr;
  face_t             face;

  assign face = FACE_TABLE[cmd.face_idx];

  always_comb begin
    case (cmd.rd_sel)
      RD_N1:   raddr = {row_r + {{(ROW_W-2){face.b1[1]}}, face.b1},
                        col_r + {{(COL_W-2){face.a1[1]}}, face.a1}};
      RD_N2:   raddr = {row_r + {{(ROW_W-2){face.b2[1]}}, face.b2},
                        col_r + {{(COL_W-2){face.a2[1]}}, face.a2}};
      default: raddr = {row_r, col_r};
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_accept && (in_command == CMD_WRITE)) begin
      mem[{in_row, in_col}] <= in_height;
    end
    rd_data_r <= mem[raddr];
  end

  // face vector
  logic [HGT_W-1:0]     h0_r, h1_r, h2_r;
  logic signed [8:0]    d1, d2;
  logic signed [9:0]    e1, e2, z1, z2;
  logic signed [10:0]   ex, ez;
  logic signed [1:0]    cy1, cy2;
  logic signed [2:0]    cy;
  logic signed [27:0]   px_r, pz_r;
  logic [31:0]          swsh_r;
  logic [39:0]          p255;
  logic [VEC_W-1:0]     pos_y;
  logic signed [VEC_W-1:0] vy;
  logic signed [VEC_W-1:0] vec_r [3];
  logic signed [VEC_W-1:0] norm_in [3];
  logic signed [Q_W-1:0]   nq [3];
  logic signed [ACC_W-1:0] acc_r [3];

  always_ff @(posedge clk) begin
    if (cmd.ld_h0) begin
      h0_r <= rd_data_r;
    end
    if (cmd.ld_h1) begin
      h1_r <= rd_data_r;
    end
    if (cmd.ld_h2) begin
      h2_r <= rd_data_r;
    end
  end

  always_comb begin
    d1    = $signed({1'b0, h1_r}) - $signed({1'b0, h0_r});
    d2    = $signed({1'b0, h2_r}) - $signed({1'b0, h0_r});
    e1    = off_mul(d1, face.b2);
    e2    = off_mul(d2, face.b1);
    z1    = off_mul(d2, face.a1);
    z2    = off_mul(d1, face.a2);
    ex    = {e1[9], e1} - {e2[9], e2};
    ez    = {z1[9], z1} - {z2[9], z2};
    cy1   = off_prod(face.b1, face.a2);
    cy2   = off_prod(face.a1, face.b2);
    cy    = {cy1[1], cy1} - {cy2[1], cy2};
    p255  = {swsh_r, 8'b0} - {8'b0, swsh_r};
    pos_y = {2'b00, p255};
    case (cy)
      3'sd1:   vy = $signed(pos_y);
      -3'sd1:  vy = -$signed(pos_y);
      3'sd2:   vy = $signed(pos_y << 1);
      -3'sd2:  vy = -$signed(pos_y << 1);
      default: vy = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      px_r   <= $signed({1'b0, step_h_r}) * ex;
      pz_r   <= $signed({1'b0, step_w_r}) * ez;
      swsh_r <= step_w_r * step_h_r;
    end
    if (cmd.mul2) begin
      vec_r[0] <= {{6{px_r[27]}}, px_r, 8'b0};
      vec_r[1] <= vy;
      vec_r[2] <= {{6{pz_r[27]}}, pz_r, 8'b0};
    end
  end

  // the final pass takes the face sum with z negated
  always_comb begin
    if (cmd.sel_final) begin
      norm_in[0] = VEC_W'(acc_r[0]);
      norm_in[1] = VEC_W'(acc_r[1]);
      norm_in[2] = -VEC_W'(acc_r[2]);
    end else begin
      norm_in = vec_r;
    end
  end

  hvn_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.norm_start),
    .frac_face (cmd.frac_face),
    .vec_in    (norm_in),
    .done      (norm_done),
    .q_out     (nq)
  );

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.clr_acc) begin
        acc_r[k] <= '0;
      end else if (cmd.acc_add) begin
        acc_r[k] <= acc_r[k] + ACC_W'(nq[k]);
      end
    end
  end

  // output register
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_x_r, out_y_r, out_z_r;
  logic                    out_err_r;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_err_r <= coord_err;
      out_x_r   <= coord_err ? '0 : sat_q(nq[0]);
      out_y_r   <= coord_err ? '0 : sat_q(nq[1]);
      out_z_r   <= coord_err ? '0 : sat_q(nq[2]);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_normal_x    = out_x_r;
  assign out_normal_y    = out_y_r;
  assign out_normal_z    = out_z_r;
  assign out_coord_error = out_err_r;

endmodule

FILE: design/hvn_ctrl.sv
// ----------------------------------------------------------------------------
// hvn_ctrl
// controller: sequences height reads, face normals and the final normal
// ----------------------------------------------------------------------------
`include "heightmap_vertex_normal_top_macros.svh"

module hvn_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic                in_command,
  input  hvn_pkg::dp_status_t st,
  output hvn_pkg::ctrl_cmd_t  cmd,
  output logic                in_stall
);
  import hvn_pkg::*;

  ctrl_state_t           state_r, state_nxt;
  logic [FACE_CNT_W-1:0] face_cnt_r, face_cnt_nxt;
  logic                  last_face;

  assign last_face = (({1'b0, face_cnt_r} + FACE_NUM_W'(1)) == st.face_count);

  always_comb begin
    state_nxt    = state_r;
    face_cnt_nxt = face_cnt_r;
    cmd          = '0;
    cmd.face_idx = st.face_start + FACE_IDX_W'(face_cnt_r);
    in_stall     = 1'b1;
    case (state_r)
      C_IDLE: begin
        in_stall = 1'b0;
        if (in_accept && (in_command == CMD_COMPUTE)) begin
          cmd.take  = 1'b1;
          state_nxt = C_CHECK;
        end
      end
      C_CHECK: begin
        if (st.coord_err) begin
          state_nxt = C_OUT;
        end else begin
          cmd.clr_acc  = 1'b1;
          face_cnt_nxt = '0;
          state_nxt    = C_RDC;
        end
      end
      C_RDC: begin
        cmd.rd_sel = RD_CENTRE;
        state_nxt  = C_LDH0;
      end
      C_LDH0: begin
        cmd.ld_h0 = 1'b1;
        state_nxt = C_RD1;
      end
      C_RD1: begin
        cmd.rd_sel = RD_N1;
        state_nxt  = C_RD2;
      end
      C_RD2: begin
        cmd.rd_sel = RD_N2;
        cmd.ld_h1  = 1'b1;
        state_nxt  = C_RD3;
      end
      C_RD3: begin
        cmd.ld_h2 = 1'b1;
        state_nxt = C_MUL1;
      end
      C_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = C_MUL2;
      end
      C_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = C_NST;
      end
      C_NST: begin
        cmd.norm_start = 1'b1;
        cmd.frac_face  = 1'b1;
        state_nxt      = C_NWAIT;
      end
      C_NWAIT: begin
        if (st.norm_done) begin
          cmd.acc_add = 1'b1;
          if (last_face) begin
            state_nxt = C_FST;
          end else begin
            face_cnt_nxt = face_cnt_r + FACE_CNT_W'(1);
            state_nxt    = C_RD1;
          end
        end
      end
      C_FST: begin
        cmd.sel_final  = 1'b1;
        cmd.norm_start = 1'b1;
        state_nxt      = C_FWAIT;
      end
      C_FWAIT: begin
        if (st.norm_done) begin
          state_nxt = C_OUT;
        end
      end
      C_OUT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= C_IDLE;
      face_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      face_cnt_r <= face_cnt_nxt;
    end
  end

  `HVN_ASSERT_NEXT(a_compute_starts, in_accept && (in_command == CMD_COMPUTE), state_r == C_CHECK, "compute item not started")
  `HVN_ASSERT_SAME(a_load_needs_room, cmd.load_out, st.out_free, "result loaded over a waiting one")
  `HVN_ASSERT_SAME(a_face_in_range, state_r == C_NWAIT, {1'b0, face_cnt_r} < st.face_count, "face counter past face count")

endmodule

FILE: design/heightmap_vertex_normal_top.sv
// ----------------------------------------------------------------------------
// heightmap_vertex_normal_top
// Heightmap store with a vertex normal unit. A write item stores one height
// byte at (row, col) and gives no result. A compute item returns the unit
// normal at (row, col) in Q1.15, averaged over the one, two or eight faces
// around the point, or coord_error with zero normal when the point lies
// outside the grid in use. For each face the memory reads and multiplies run
// through the states C_RD1, C_RD2, C_RD3, C_MUL1 and C_MUL2, then it takes
// one pass through the shared normaliser, whose square root gives one result
// bit per cycle and whose divider gives one quotient bit per cycle per
// component; the final normal takes one more, shorter pass. One item is in
// work at a time, and a finished result waits in the output register while
// the next item is taken. Heights read before they were written are
// undefined.
// ----------------------------------------------------------------------------
module heightmap_vertex_normal_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hvn_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hvn_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic [hvn_pkg::ROW_W-1:0]         in_row,
  input  logic [hvn_pkg::COL_W-1:0]         in_col,
  input  logic [hvn_pkg::HGT_W-1:0]         in_height,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [hvn_pkg::OUT_W-1:0]  out_normal_x,
  output logic signed [hvn_pkg::OUT_W-1:0]  out_normal_y,
  output logic signed [hvn_pkg::OUT_W-1:0]  out_normal_z,
  output logic                              out_coord_error
);
  import hvn_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;
  logic       in_accept;

  assign in_accept = in_valid && !in_stall;

  hvn_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .in_command (in_command),
    .st         (st),
    .cmd        (cmd),
    .in_stall   (in_stall)
  );

  hvn_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_accept       (in_accept),
    .in_command      (in_command),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_height       (in_height),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_normal_x    (out_normal_x),
    .out_normal_y    (out_normal_y),
    .out_normal_z    (out_normal_z),
    .out_coord_error (out_coord_error)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the heightmap vertex normal unit. Before each
// compute in the grid it writes any height around the point that is still
// unwritten, and it sends write and compute items under several grid and
// spacing settings. Each compute is predicted in the bench, and each result
// is compared field by field in the order the items went in.
// ----------------------------------------------------------------------------
module tb;
  import hvn_pkg::*;

  localparam longint CYCLE_LIMIT = 6000000;
  localparam int     ITEM_TARGET = 1250;

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               err;
  } normal_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_command;
  logic [ROW_W-1:0]      in_row;
  logic [COL_W-1:0]      in_col;
  logic [HGT_W-1:0]      in_height;
  logic                  out_valid;
  logic                  out_stall;
  logic signed [15:0]    out_normal_x;
  logic signed [15:0]    out_normal_y;
  logic signed [15:0]    out_normal_z;
  logic                  out_coord_error;

  // own copy of the store and registers
  logic [7:0]  heights [DEPTH];
  bit          written [DEPTH];
  int unsigned grid_cols, grid_rows, col_step, row_step;

  normal_t     pending_normals[$];
  int          idle_mode;
  int          failures;
  int          n_items, n_settings;
  int          n_writes, n_computes, n_results, n_edge_errs;
  longint      cycles;

  // offsets a1 b1 a2 b2 of the faces around a point
  int face_offs [20][4] = '{
    '{0, 1, 1, 0}, '{0, -1, -1, 0}, '{1, 0, 0, -1}, '{-1, 0, 0, 1},
    '{-1, 0, 0, 1}, '{0, 1, 1, 0}, '{1, 0, 0, -1}, '{0, 1, 1, 0},
    '{0, -1, -1, 0}, '{1, 0, 0, -1}, '{0, -1, -1, 0}, '{-1, 0, 0, 1},
    '{-1, 0, -1, 1}, '{-1, 1, 0, 1}, '{0, 1, 1, 1}, '{1, 1, 1, 0},
    '{1, 0, 1, -1}, '{1, -1, 0, -1}, '{0, -1, -1, -1}, '{-1, -1, -1, 0}
  };

  heightmap_vertex_normal_top uut (.*);

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  task automatic scale_to_unit(input longint v[3], input int frac, output longint w[3]);
    longint unsigned mag[3], mx, sum, r, q;
    bit neg[3];
    mx = 0;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      neg[k] = v[k] < 0;
      mag[k] = neg[k] ? -v[k] : v[k];
      if (mag[k] > mx) mx = mag[k];
    end
    if (mx == 0) begin
      w = '{0, 0, 0};
      return;
    end
    while (mx >= (64'd1 << 30)) begin
      mx >>= 1;
      for (int k = 0; k < 3; k++) mag[k] >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      mx <<= 1;
      for (int k = 0; k < 3; k++) mag[k] <<= 1;
    end
    for (int k = 0; k < 3; k++) sum += mag[k] * mag[k];
    r = int_sqrt(sum);
    for (int k = 0; k < 3; k++) begin
      q = ((mag[k] << frac) + (r >> 1)) / r;
      w[k] = neg[k] ? -longint'(q) : longint'(q);
    end
  endtask

  function automatic longint height_at(input int r, input int c);
    if (r < 0 || c < 0 || r >= MAX_ROWS || c >= MAX_COLS) return 0;
    return longint'(heights[r * MAX_COLS + c]);
  endfunction

  function automatic int cols_used();
    if (grid_cols < 2) return 2;
    if (grid_cols > MAX_COLS) return MAX_COLS;
    return int'(grid_cols);
  endfunction

  function automatic int rows_used();
    if (grid_rows < 2) return 2;
    if (grid_rows > MAX_ROWS) return MAX_ROWS;
    return int'(grid_rows);
  endfunction

  function automatic bit in_grid(input int r, input int c);
    return (r < rows_used()) && (c < cols_used());
  endfunction

  // corners and borders picked often
  function automatic int pick_coord(input int n);
    int sel;
    sel = $urandom_range(9);
    if (sel < 5) return $urandom_range(2) % n;
    if (sel < 8) return n - 1 - ($urandom_range(2) % n);
    return $urandom_range(n - 1);
  endfunction

  task automatic vertex_normal(input int r, input int c, output normal_t res);
    int gw, gh, lw, lh, first, count;
    longint acc[3], fn[3], un[3], fin[3];
    longint a1, b1, a2, b2, h0, h1, h2, sw, sh;
    gw = grid_cols < 2 ? 2 : (grid_cols > MAX_COLS ? MAX_COLS : grid_cols);
    gh = grid_rows < 2 ? 2 : (grid_rows > MAX_ROWS ? MAX_ROWS : grid_rows);
    res.nx = 0; res.ny = 0; res.nz = 0; res.err = 1'b0;
    if (r >= gh || c >= gw) begin
      res.err = 1'b1;
      return;
    end
    lw = gw - 1;
    lh = gh - 1;
    if (r == 0 && c == 0) begin first = 0; count = 1; end
    else if (r == lh && c == lw) begin first = 1; count = 1; end
    else if (r == lh && c == 0) begin first = 2; count = 1; end
    else if (r == 0 && c == lw) begin first = 3; count = 1; end
    else if (r == 0) begin first = 4; count = 2; end
    else if (c == 0) begin first = 6; count = 2; end
    else if (r == lh) begin first = 8; count = 2; end
    else if (c == lw) begin first = 10; count = 2; end
    else begin first = 12; count = 8; end
    acc = '{0, 0, 0};
    sw = col_step;
    sh = row_step;
    for (int k = 0; k < count; k++) begin
      a1 = face_offs[first + k][0];
      b1 = face_offs[first + k][1];
      a2 = face_offs[first + k][2];
      b2 = face_offs[first + k][3];
      h0 = height_at(r, c);
      h1 = height_at(r + int'(b1), c + int'(a1)) - h0;
      h2 = height_at(r + int'(b2), c + int'(a2)) - h0;
      fn[0] = 256 * sh * (h1 * b2 - b1 * h2);
      fn[1] = 255 * sw * sh * (b1 * a2 - a1 * b2);
      fn[2] = 256 * sw * (a1 * h2 - h1 * a2);
      scale_to_unit(fn, FRAC_FACE, un);
      for (int j = 0; j < 3; j++) acc[j] += un[j];
    end
    acc[2] = -acc[2];
    scale_to_unit(acc, FRAC_FINAL, fin);
    for (int j = 0; j < 3; j++) begin
      if (fin[j] > 32767) fin[j] = 32767;
      if (fin[j] < -32768) fin[j] = -32768;
    end
    res.nx = fin[0][15:0];
    res.ny = fin[1][15:0];
    res.nz = fin[2][15:0];
  endtask

  // result side: check and choose the next stall
  always @(posedge clk) begin
    normal_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_normals.size() == 0) begin
        $error("result with no compute waiting");
        failures++;
      end else begin
        want = pending_normals.pop_front();
        if (out_normal_x !== want.nx) begin
          $error("normal_x expected %0d got %0d", want.nx, out_normal_x);
          failures++;
        end
        if (out_normal_y !== want.ny) begin
          $error("normal_y expected %0d got %0d", want.ny, out_normal_y);
          failures++;
        end
        if (out_normal_z !== want.nz) begin
          $error("normal_z expected %0d got %0d", want.nz, out_normal_z);
          failures++;
        end
        if (out_coord_error !== want.err) begin
          $error("coord_error expected %0b got %0b", want.err, out_coord_error);
          failures++;
        end
      end
    end
    case (idle_mode)
      2: out_stall <= ($urandom_range(99) < 69);
      3: out_stall <= ($urandom_range(99) < 7);
      default: out_stall <= 1'b0;
    endcase
  end

  task automatic send_item(input logic cmd, input int r, input int c, input int h);
    normal_t want;
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_row     <= r[ROW_W-1:0];
    in_col     <= c[COL_W-1:0];
    in_height  <= h[HGT_W-1:0];
    do @(posedge clk); while (in_stall);
    n_items++;
    if (cmd == CMD_WRITE) begin
      heights[r * MAX_COLS + c] = h[7:0];
      written[r * MAX_COLS + c] = 1'b1;
      n_writes++;
    end else begin
      vertex_normal(r, c, want);
      pending_normals.push_back(want);
      n_computes++;
      if (want.err) n_edge_errs++;
    end
    if ((idle_mode == 1 && $urandom_range(99) < 69) ||
        (idle_mode == 3 && $urandom_range(99) < 7)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // a compute only reads heights that have been written
  task automatic send_compute(input int r, input int c);
    int rr, cc;
    if (in_grid(r, c)) begin
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          rr = r + dr;
          cc = c + dc;
          if (rr >= 0 && cc >= 0 && rr < MAX_ROWS && cc < MAX_COLS &&
              !written[rr * MAX_COLS + cc]) begin
            send_item(CMD_WRITE, rr, cc, $urandom_range(255));
          end
        end
      end
    end
    send_item(CMD_COMPUTE, r, c, 0);
  endtask

  // sender pauses until the block has gone quiet
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    case (idx)
      REG_GRID_WIDTH:  grid_cols = value & 8'hFF;
      REG_GRID_HEIGHT: grid_rows = value & 8'hFF;
      REG_STEP_WIDTH:  col_step = value & 16'hFFFF;
      default:         row_step = value & 16'hFFFF;
    endcase
  endtask

  task automatic set_grid(input int gw, input int gh, input int sw, input int sh);
    drain();
    write_reg(REG_GRID_WIDTH, gw);
    write_reg(REG_GRID_HEIGHT, gh);
    write_reg(REG_STEP_WIDTH, sw);
    write_reg(REG_STEP_HEIGHT, sh);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic test_reset_grid;
    send_item(CMD_WRITE, 127, 127, 255);
    send_item(CMD_WRITE, 0, 0, 0);
    send_compute(0, 0);
    send_compute(127, 127);
    send_compute(127, 0);
    send_compute(0, 127);
    send_compute(0, 40);
    send_compute(40, 0);
    send_compute(127, 40);
    send_compute(40, 127);
    send_compute(64, 64);
  endtask

  task automatic test_grid_extremes;
    // 2x2 grid: every point a corner, others out of the grid
    set_grid(2, 2, 1, 65535);
    send_compute(1, 1);
    send_compute(0, 1);
    send_compute(2, 0);
    send_compute(0, 2);
    // sizes past the range are clamped
    set_grid(0, 255, 65535, 1);
    send_compute(1, 1);
    send_compute(127, 0);
    set_grid(200, 1, 256, 256);
    send_compute(1, 127);
    send_compute(1, 50);
  endtask

  task automatic test_zero_spacing;
    set_grid(16, 16, 0, 0);
    send_compute(5, 5);
    send_compute(0, 0);
    set_grid(16, 16, 0, 300);
    send_compute(0, 7);
  endtask

  task automatic test_random_mix;
    int gw, gh, sw, sh, r, c, base, budget;
    base   = n_items;
    budget = (ITEM_TARGET > base + 100) ? ITEM_TARGET - base : 100;
    for (int ph = 0; ph < 10; ph++) begin
      gw = (ph % 3 == 0) ? $urandom_range(255) : $urandom_range(2, 128);
      gh = (ph % 4 == 1) ? $urandom_range(255) : $urandom_range(2, 128);
      sw = (ph == 7) ? 65535 : $urandom_range(1, 1024);
      sh = (ph == 8) ? 1 : $urandom_range(1, 65535);
      set_grid(gw, gh, sw, sh);
      idle_mode = ph % 4;
      if (ph == 5) drain();
      while (n_items < base + (budget * (ph + 1)) / 10) begin
        r = $urandom_range(127);
        c = $urandom_range(127);
        if ($urandom_range(99) < 62) begin
          send_item(CMD_WRITE, r, c, $urandom_range(255));
        end else begin
          // mostly points in the grid, borders often
          if ($urandom_range(9) < 8) begin
            r = pick_coord(rows_used());
            c = pick_coord(cols_used());
          end
          send_compute(r, c);
        end
      end
    end
  endtask

  initial begin
    rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    in_valid = 1'b0; in_command = 1'b0; in_row = '0; in_col = '0;
    in_height = '0; out_stall = 1'b0;
    cycles = 0; failures = 0; idle_mode = 0; n_items = 0; n_settings = 0;
    n_writes = 0; n_computes = 0; n_results = 0; n_edge_errs = 0;
    grid_cols = 128; grid_rows = 128; col_step = 256; row_step = 256;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_grid();
    test_grid_extremes();
    test_zero_spacing();
    test_random_mix();
    drain();
    repeat (200) @(posedge clk);
    $display("ran %0d height writes and %0d normal computes, %0d results checked",
             n_writes, n_computes, n_results);
    $display("%0d computes fell outside the grid; %0d grid and spacing settings used",
             n_edge_errs, n_settings);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/hvn_pkg.sv
design/hvn_norm.sv
design/hvn_dp.sv
design/hvn_ctrl.sv
design/heightmap_vertex_normal_top.sv
tb/tb.sv
